### rtl/ndrm_pkg.sv
// Package for the nearest delta-R matcher: field widths, reset values and
// register indexes. It depends on nothing and is compiled first.
package ndrm_pkg;

    localparam int ETA_W  = 11;
    localparam int PHI_W  = 10;
    localparam int DIST_W = 23;
    localparam int IDX_W  = 6;
    localparam int ETA_SQ_W = 22;
    localparam int PHI_SQ_W = 19;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [DIST_W-1:0] DIST_ONES     = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] MAX_DR_SQ_RST = 23'd4250;

    typedef enum logic [0:0] {
        REG_MAX_DR_SQ = 1'b0
    } t_reg_idx;

    typedef logic signed [ETA_W-1:0] t_eta;
    typedef logic [PHI_W-1:0]        t_phi;
    typedef logic [DIST_W-1:0]       t_dist;

endpackage

### rtl/ndrm_if.sv
// Valid/ready channel interfaces for the matcher's candidate and result items.
// Depends on ndrm_pkg for field types.
interface ndrm_in_if;
    logic              valid;
    logic              ready;
    ndrm_pkg::t_eta    ref_eta;
    ndrm_pkg::t_phi    ref_phi;
    ndrm_pkg::t_eta    obj_eta;
    ndrm_pkg::t_phi    obj_phi;
    logic              object_present;
    logic              last_object;

    modport source (output valid, ref_eta, ref_phi, obj_eta, obj_phi,
                    object_present, last_object, input ready);
    modport sink   (input valid, ref_eta, ref_phi, obj_eta, obj_phi,
                    object_present, last_object, output ready);
endinterface

interface ndrm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          matched;
    logic [ndrm_pkg::IDX_W-1:0]    match_index;
    ndrm_pkg::t_dist               min_dr_sq;
    logic                          list_overflow;

    modport source (output valid, matched, match_index, min_dr_sq, list_overflow,
                    input ready);
    modport sink   (input valid, matched, match_index, min_dr_sq, list_overflow,
                    output ready);
endinterface

### rtl/ndrm_dist.sv
// Squared eta and phi differences of one candidate, with phi wrapped to
// half a turn either way. Depends on ndrm_pkg.
module ndrm_dist (
    input  ndrm_pkg::t_eta                   i_ref_eta,
    input  ndrm_pkg::t_phi                   i_ref_phi,
    input  ndrm_pkg::t_eta                   i_obj_eta,
    input  ndrm_pkg::t_phi                   i_obj_phi,
    output logic [ndrm_pkg::ETA_SQ_W-1:0]    o_eta_sq,
    output logic [ndrm_pkg::PHI_SQ_W-1:0]    o_phi_sq
);

    logic signed [ndrm_pkg::ETA_W:0]       w_deta;
    logic [ndrm_pkg::PHI_W-1:0]            w_dp;
    logic signed [ndrm_pkg::PHI_W-1:0]     w_dphi;
    logic signed [2*ndrm_pkg::ETA_W+1:0]   w_eta_prod;
    logic signed [2*ndrm_pkg::PHI_W-1:0]   w_phi_prod;

    // The modular phi difference read as two's complement is already wrapped.
    assign w_deta     = $signed({i_ref_eta[ndrm_pkg::ETA_W-1], i_ref_eta})
                      - $signed({i_obj_eta[ndrm_pkg::ETA_W-1], i_obj_eta});
    assign w_dp       = i_ref_phi - i_obj_phi;
    assign w_dphi     = $signed(w_dp);
    assign w_eta_prod = w_deta * w_deta;
    assign w_phi_prod = w_dphi * w_dphi;
    assign o_eta_sq   = w_eta_prod[ndrm_pkg::ETA_SQ_W-1:0];
    assign o_phi_sq   = w_phi_prod[ndrm_pkg::PHI_SQ_W-1:0];

endmodule

### rtl/nearest_delta_r_match.sv
// Top level of the nearest delta-R matcher: input staging, running minimum
// and result register. Depends on ndrm_pkg, ndrm_if and ndrm_dist.
//
// Each candidate item on i_in carries a reference and one object position.
// Items stream one per clock unless o_out stalls; an item with last_object
// set closes the list and one result item appears on o_out with the match
// flag, the position of the nearest object, its squared delta-R and the
// overflow flag. An item passes an input register and a squaring register,
// and the running minimum is updated from the squaring register, whose
// closing item loads the result register. Without stalls the rate is one
// item per cycle, as the running minimum is compared and updated per item.
// When o_out stalls, items that do not close a list keep flowing; an item
// that closes a list waits in the squaring register, and i_in.ready drops
// once the input register behind it holds the next item.
// The match limit max_dr_sq is written through the APB port at address 0.
// A synchronous reset empties the pipeline, clears the running list state
// and sets max_dr_sq to 4250.
module nearest_delta_r_match #(
    parameter int MAX_OBJECTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ndrm_in_if.sink                       i_in,
    ndrm_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ndrm_pkg::APB_AW-1:0]   paddr,
    input  logic [ndrm_pkg::APB_DW-1:0]   pwdata,
    output logic [ndrm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam int POS_W = $clog2(MAX_OBJECTS);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_OBJECTS);

    ndrm_pkg::t_dist                  r_max_dr_sq;

    logic                             r_s1_valid;
    ndrm_pkg::t_eta                   r_s1_ref_eta;
    ndrm_pkg::t_phi                   r_s1_ref_phi;
    ndrm_pkg::t_eta                   r_s1_obj_eta;
    ndrm_pkg::t_phi                   r_s1_obj_phi;
    logic                             r_s1_present;
    logic                             r_s1_last;

    logic                             r_s2_valid;
    logic [ndrm_pkg::ETA_SQ_W-1:0]    r_s2_eta_sq;
    logic [ndrm_pkg::PHI_SQ_W-1:0]    r_s2_phi_sq;
    logic                             r_s2_present;
    logic                             r_s2_last;

    ndrm_pkg::t_dist                  r_best;
    logic [POS_W-1:0]                 r_pos;
    logic [CNT_W-1:0]                 r_count;
    logic                             r_found;
    logic                             r_ovf;

    ndrm_pkg::t_dist                  n_best;
    logic [POS_W-1:0]                 n_pos;
    logic [CNT_W-1:0]                 n_count;
    logic                             n_found;
    logic                             n_ovf;
    logic                             n_matched;

    logic                             r_out_valid;
    logic                             r_out_matched;
    logic [ndrm_pkg::IDX_W-1:0]       r_out_index;
    ndrm_pkg::t_dist                  r_out_dist;
    logic                             r_out_ovf;

    logic [ndrm_pkg::ETA_SQ_W-1:0]    w_eta_sq;
    logic [ndrm_pkg::PHI_SQ_W-1:0]    w_phi_sq;
    ndrm_pkg::t_dist                  w_dist;
    logic                             w_full;
    logic                             w_take;
    logic                             w_better;
    logic                             w_out_free;
    logic                             w_s2_adv;
    logic                             w_s2_free;
    logic                             w_s1_adv;
    logic                             w_s1_free;
    logic                             w_close;
    logic                             w_cfg_wr;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s2_adv   = r_s2_valid && (!r_s2_last || w_out_free);
    assign w_s2_free  = !r_s2_valid || w_s2_adv;
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s1_adv;
    assign w_close    = w_s2_adv && r_s2_last;
    assign i_in.ready = w_s1_free;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                   && (paddr[2] == ndrm_pkg::REG_MAX_DR_SQ);
    assign prdata   = (paddr[2] == ndrm_pkg::REG_MAX_DR_SQ)
                    ? ndrm_pkg::APB_DW'(r_max_dr_sq) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dr_sq <= ndrm_pkg::MAX_DR_SQ_RST;
        end else if (w_cfg_wr) begin
            r_max_dr_sq <= pwdata[ndrm_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_s1_free) begin
            r_s1_ref_eta <= i_in.ref_eta;
            r_s1_ref_phi <= i_in.ref_phi;
            r_s1_obj_eta <= i_in.obj_eta;
            r_s1_obj_phi <= i_in.obj_phi;
            r_s1_present <= i_in.object_present;
            r_s1_last    <= i_in.last_object;
        end
    end

    ndrm_dist u_dist (
        .i_ref_eta (r_s1_ref_eta),
        .i_ref_phi (r_s1_ref_phi),
        .i_obj_eta (r_s1_obj_eta),
        .i_obj_phi (r_s1_obj_phi),
        .o_eta_sq  (w_eta_sq),
        .o_phi_sq  (w_phi_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s2_eta_sq  <= w_eta_sq;
            r_s2_phi_sq  <= w_phi_sq;
            r_s2_present <= r_s1_present;
            r_s2_last    <= r_s1_last;
        end
    end

    assign w_dist   = ndrm_pkg::DIST_W'(r_s2_eta_sq) + ndrm_pkg::DIST_W'(r_s2_phi_sq);
    assign w_full   = (r_count == CNT_FULL);
    assign w_take   = r_s2_present && !w_full;
    assign w_better = w_take && (w_dist < r_best);

    always_comb begin
        n_best    = w_better ? w_dist : r_best;
        n_pos     = w_better ? r_count[POS_W-1:0] : r_pos;
        n_count   = w_take ? r_count + CNT_W'(1) : r_count;
        n_found   = r_found || w_take;
        n_ovf     = r_ovf || (r_s2_present && w_full);
        n_matched = n_found && (n_best < r_max_dr_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best  <= ndrm_pkg::DIST_ONES;
            r_pos   <= '0;
            r_count <= '0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_close) begin
            r_best  <= ndrm_pkg::DIST_ONES;
            r_pos   <= '0;
            r_count <= '0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_s2_adv) begin
            r_best  <= n_best;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_found <= n_found;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_close) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_out_matched <= n_matched;
            r_out_index   <= n_matched ? ndrm_pkg::IDX_W'(n_pos) : '0;
            r_out_dist    <= n_best;
            r_out_ovf     <= n_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.matched       = r_out_matched;
    assign o_out.match_index   = r_out_index;
    assign o_out.min_dr_sq     = r_out_dist;
    assign o_out.list_overflow = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("object count exceeds capacity");

    a_clear_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> (r_best == ndrm_pkg::DIST_ONES) && (r_count == '0)
                    && !r_found && !r_ovf)
        else $error("list state not cleared after a closing item");

    a_match_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_matched) |-> (r_out_dist < r_max_dr_sq))
        else $error("match reported at or above the limit");

    a_close_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |-> w_out_free)
        else $error("result overwrites an undelivered result");

    a_found_when_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_found)
        else $error("objects counted but none recorded as found");

endmodule
